### sv/slq_pkg.sv
package slq_pkg;

   // Traffic class codes.
   localparam logic [1:0] CLS_EMBB     = 2'd0;
   localparam logic [1:0] CLS_URLLC    = 2'd1;
   localparam logic [1:0] CLS_MMTC     = 2'd2;
   localparam logic [1:0] CLS_OVERLOAD = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LEARNING_RATE     = 2'd0;
   localparam logic [1:0] CSR_DISCOUNT          = 2'd1;
   localparam logic [1:0] CSR_EXPLORE_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_OVERLOAD_LIMIT    = 2'd3;

   // Configuration reset values.
   localparam logic [15:0] LEARNING_RATE_RST     = 16'd6554;
   localparam logic [15:0] DISCOUNT_RST          = 16'd58982;
   localparam logic [15:0] EXPLORE_THRESHOLD_RST = 16'd6554;
   localparam logic [23:0] OVERLOAD_LIMIT_RST    = 24'd76800;

   // Payload widths.
   localparam int unsigned REQ_DATA_W = 168;
   localparam int unsigned RSP_DATA_W = 64;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned REWARD_W   = 6;
   localparam int unsigned SHARE_W    = 7;

   // Reward table, indexed by {class, previous action}.
   localparam logic signed [REWARD_W-1:0] REWARD_LUT [16] = '{
      -6'sd5,  6'sd5,  6'sd0,  6'sd0,
       6'sd10, 6'sd5,  6'sd0, -6'sd10,
      -6'sd10, 6'sd5,  6'sd10, -6'sd5,
      -6'sd20, -6'sd20, -6'sd20, -6'sd20
   };

   // Bandwidth shares in percent, indexed by class.
   localparam logic [SHARE_W-1:0] SHARE_EMBB_LUT  [4] = '{7'd60, 7'd20, 7'd20, 7'd33};
   localparam logic [SHARE_W-1:0] SHARE_URLLC_LUT [4] = '{7'd20, 7'd60, 7'd20, 7'd33};
   localparam logic [SHARE_W-1:0] SHARE_MMTC_LUT  [4] = '{7'd20, 7'd20, 7'd60, 7'd34};

   // Commands from the controller to the datapath, one per step.
   typedef struct packed {
      logic load;    // capture the transaction, classify, read the class row
      logic pick;    // choose the action, find the best value, fetch the entry
      logic mul1;    // discount times best value
      logic tgt;     // form the target
      logic diff;    // target minus old entry
      logic mul2;    // learning rate times difference
      logic commit;  // write back the entry, load the result register
   } slq_cmd_type;

endpackage

### sv/slq_ctrl.sv
module slq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output slq_pkg::slq_cmd_type cmd
);
   import slq_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PICK   = 7'b0000010,
      ST_MUL1   = 7'b0000100,
      ST_TGT    = 7'b0001000,
      ST_DIFF   = 7'b0010000,
      ST_MUL2   = 7'b0100000,
      ST_COMMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Step sequencing and result handshake.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_TGT;
         end
         ST_TGT: begin
            cmd.tgt  = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // The result register must be free or emptying this cycle.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/slq_dpath.sv
module slq_dpath #(
   parameter int unsigned Q_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  slq_pkg::slq_cmd_type               cmd,
   input  logic [slq_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [slq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   input  logic [1:0]                         csr_index,
   input  logic [slq_pkg::CSR_DATA_W-1:0]     csr_data
);
   import slq_pkg::*;

   localparam int unsigned TGT_W   = ((Q_FRAC_BITS + REWARD_W > 33) ?
                                      (Q_FRAC_BITS + REWARD_W) : 33) + 1;
   localparam int unsigned DIFF_W  = TGT_W + 1;
   localparam int unsigned PROD2_W = DIFF_W + 17;
   localparam int unsigned STEP_W  = PROD2_W - 16;
   localparam int unsigned NV_W    = STEP_W + 1;
   localparam int unsigned ROW_W   = 4 * VALUE_W;

   localparam logic [47:0]               HALF1 = 48'd32768;
   localparam logic signed [PROD2_W-1:0] HALF2 = PROD2_W'(32768);
   localparam logic signed [NV_W-1:0]    VMAX  = NV_W'(64'sh7FFFFFFF);
   localparam logic signed [NV_W-1:0]    VMIN  = NV_W'(-64'sh80000000);

   // Configuration registers.
   logic [15:0] lrate_ff, disc_ff, thresh_ff;
   logic [23:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lrate_ff  <= LEARNING_RATE_RST;
         disc_ff   <= DISCOUNT_RST;
         thresh_ff <= EXPLORE_THRESHOLD_RST;
         limit_ff  <= OVERLOAD_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:     lrate_ff  <= csr_data[15:0];
            CSR_DISCOUNT:          disc_ff   <= csr_data[15:0];
            CSR_EXPLORE_THRESHOLD: thresh_ff <= csr_data[15:0];
            CSR_OVERLOAD_LIMIT:    limit_ff  <= csr_data;
            default:               lrate_ff  <= lrate_ff;
         endcase
      end
   end

   // Input fields.
   logic [31:0] embb, urllc, mmtc;
   logic [23:0] cpu, mem;
   logic [15:0] draw;
   logic [1:0]  rnd;
   logic [1:0]  cls_c;

   assign embb  = req_tdata[31:0];
   assign urllc = req_tdata[63:32];
   assign mmtc  = req_tdata[95:64];
   assign cpu   = req_tdata[119:96];
   assign mem   = req_tdata[143:120];
   assign draw  = req_tdata[159:144];
   assign rnd   = req_tdata[161:160];

   // Classification; every throughput tie falls to the machine-type class.
   always_comb begin
      if ((cpu > limit_ff) || (mem > limit_ff)) begin
         cls_c = CLS_OVERLOAD;
      end else if ((embb > urllc) && (embb > mmtc)) begin
         cls_c = CLS_EMBB;
      end else if ((urllc > embb) && (urllc > mmtc)) begin
         cls_c = CLS_URLLC;
      end else begin
         cls_c = CLS_MMTC;
      end
   end

   // Value table: one row of four entries per class, with a valid bit per row.
   logic [ROW_W-1:0] row_mem [4];
   logic [3:0]       row_valid_ff;
   logic [ROW_W-1:0] rd_row_ff;
   logic             rd_vld_ff;
   logic [1:0]       cls_ff, rnd_ff, last_act_ff;
   logic [1:0]       act_ff;
   logic             explore_ff;
   logic [ROW_W-1:0] wr_row;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rd_row_ff  <= row_mem[cls_c];
         rd_vld_ff  <= row_valid_ff[cls_c];
         cls_ff     <= cls_c;
         rnd_ff     <= rnd;
         explore_ff <= (draw < thresh_ff);
      end
      if (cmd.commit) begin
         row_mem[cls_ff] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         last_act_ff  <= 2'd3;
      end else if (cmd.commit) begin
         row_valid_ff[cls_ff] <= 1'b1;
         last_act_ff          <= act_ff;
      end
   end

   // Entries of the class row; a row never written reads as zero.
   logic signed [VALUE_W-1:0] ent [4];

   always_comb begin
      for (int a = 0; a < 4; a++) begin
         ent[a] = rd_vld_ff ? signed'(rd_row_ff[a*VALUE_W +: VALUE_W]) : '0;
      end
   end

   // Greedy choice with lowest index on ties, and the best value floored at zero.
   logic [1:0]                greedy_act;
   logic signed [VALUE_W-1:0] row_max;
   logic [30:0]               best_c;

   always_comb begin
      greedy_act = 2'd0;
      row_max    = ent[0];
      for (int a = 1; a < 4; a++) begin
         if (ent[a] > row_max) begin
            row_max    = ent[a];
            greedy_act = 2'(a);
         end
      end
      best_c = row_max[VALUE_W-1] ? '0 : row_max[30:0];
   end

   logic [30:0]                best_ff;
   logic signed [VALUE_W-1:0]  old_ff;
   logic signed [REWARD_W-1:0] rew_ff;

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         act_ff  <= explore_ff ? rnd_ff : greedy_act;
         best_ff <= best_c;
         old_ff  <= ent[last_act_ff];
         rew_ff  <= REWARD_LUT[{cls_ff, last_act_ff}];
      end
   end

   // Discounted best value, rounded to nearest with ties up.
   logic [46:0]              prod1_ff;
   logic [47:0]              prod1_rnd;
   logic signed [TGT_W-1:0]  rew_ext, rew_sh, target_c, target_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod1_ff <= 47'(disc_ff) * 47'(best_ff);
      end
   end

   assign prod1_rnd = {1'b0, prod1_ff} + HALF1;
   assign rew_ext   = {{(TGT_W-REWARD_W){rew_ff[REWARD_W-1]}}, rew_ff};
   assign rew_sh    = rew_ext <<< Q_FRAC_BITS;
   assign target_c  = rew_sh + signed'({{(TGT_W-32){1'b0}}, prod1_rnd[47:16]});

   always_ff @(posedge clock) begin
      if (cmd.tgt) begin
         target_ff <= target_c;
      end
   end

   // Difference to the old entry and the learning-rate step.
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [PROD2_W-1:0] prod2_ff, prod2_rnd;
   logic signed [16:0]        lrate_ext;

   assign lrate_ext = signed'({1'b0, lrate_ff});

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         diff_ff <= {target_ff[TGT_W-1], target_ff}
                    - {{(DIFF_W-VALUE_W){old_ff[VALUE_W-1]}}, old_ff};
      end
      if (cmd.mul2) begin
         prod2_ff <= PROD2_W'(lrate_ext) * PROD2_W'(diff_ff);
      end
   end

   // New entry, saturated to the signed 32-bit range.
   logic signed [NV_W-1:0]    nv;
   logic signed [VALUE_W-1:0] nv_sat;

   assign prod2_rnd = prod2_ff + HALF2;
   assign nv = {{(NV_W-VALUE_W){old_ff[VALUE_W-1]}}, old_ff}
               + {prod2_rnd[PROD2_W-1], prod2_rnd[PROD2_W-1:16]};

   always_comb begin
      if (nv > VMAX) begin
         nv_sat = VMAX[VALUE_W-1:0];
      end else if (nv < VMIN) begin
         nv_sat = VMIN[VALUE_W-1:0];
      end else begin
         nv_sat = nv[VALUE_W-1:0];
      end
   end

   // Row written back: the updated entry replaces the one of the previous action.
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         wr_row[a*VALUE_W +: VALUE_W] = (2'(a) == last_act_ff) ? nv_sat : ent[a];
      end
   end

   // Result register.
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {1'b0,
                         SHARE_MMTC_LUT[cls_ff],
                         SHARE_URLLC_LUT[cls_ff],
                         SHARE_EMBB_LUT[cls_ff],
                         nv_sat,
                         rew_ff,
                         act_ff,
                         cls_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

### sv/slice_qlearning_controller.sv
// Channel  | Direction | Ports                            | Payload
// ---------+-----------+----------------------------------+-----------------------------------
// req      | in        | req_tvalid/req_tready/req_tdata  | slice rates, server loads, draws
// rsp      | out       | rsp_tvalid/rsp_tready/rsp_tdata  | class, action, reward, value, shares
// csr      | in        | csr_valid/csr_ready/csr_index/.. | configuration register writes
//
// A transaction holds the controller from acceptance to write-back: the accepting edge reads the
// class row, then selection, discount multiply, target add, difference, learning-rate
// multiply and write-back follow in turn; the next transaction is accepted once back in idle.
// Reset is synchronous; it restores the configuration defaults, invalidates all rows (an
// invalid row reads as zero) and sets the previous action to three.
// A waiting result holds the write-back step until the result register is free.
module slice_qlearning_controller #(
   parameter int unsigned Q_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // embb_rate[31:0], urllc_rate[63:32], mmtc_rate[95:64], server_cpu[119:96],
   // server_mem[143:120], explore_draw[159:144], random_action[161:160], zeros above
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [slq_pkg::REQ_DATA_W-1:0] req_tdata,
   // traffic_class[1:0], chosen_action[3:2], tick_reward[9:4], updated_value[41:10],
   // share_embb[48:42], share_urllc[55:49], share_mmtc[62:56], zero at bit 63
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [slq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [slq_pkg::CSR_DATA_W-1:0] csr_data
);
   import slq_pkg::*;

   slq_cmd_type cmd;

   // Configuration writes are taken at any time.
   assign csr_ready = 1'b1;

   slq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   slq_dpath #(
      .Q_FRAC_BITS (Q_FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
